>>> src/pwli_pkg.sv
// shared constants and codes for the piecewise linear interpolation slope unit
// no dependencies
package pwli_pkg;

  localparam int DEF_MAX_SAMPLES = 32;

  localparam int CNT_W   = 6;
  localparam int IDX_W   = 5;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT = 2'd2;

  localparam logic [CNT_W-1:0] MIN_SAMPLES = 6'd2;

  // serial unit step count: one quotient bit per cycle over the full dividend
  localparam int DIV_STEPS = 65;
  localparam int MUL_STEPS = 32;

endpackage

>>> src/piecewise_linear_interp_slope_unit.sv
// piecewise linear interpolation with slope over a loaded breakpoint table
// depends on pwli_pkg
// sequence: a load goes straight to the result strobe; a query scans the n table entries, fetches
// the segment ends and the energy entry, divides for the slope and, when interpolating, multiplies
// and divides again; a zero-width segment or a point in no segment skips the slope division
// one item at a time, busy throughout; result strobe lasts one cycle, no stall
// reset: synchronous active-low, clears control and num_samples to 2; table is not cleared
module piecewise_linear_interp_slope_unit #(
  parameter int MAX_SAMPLES = pwli_pkg::DEF_MAX_SAMPLES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_req_type,
  input  logic [pwli_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [pwli_pkg::DATA_W-1:0]   in_r_value,
  input  logic signed [pwli_pkg::DATA_W-1:0]   in_e_value,
  output logic                                 out_valid,
  output logic signed [pwli_pkg::DATA_W-1:0]   out_energy,
  output logic signed [pwli_pkg::DATA_W-1:0]   out_slope,
  output logic [pwli_pkg::STAT_W-1:0]          out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pwli_pkg::CNT_W-1:0]           cfg_num_samples
);
  import pwli_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_FETCH, S_SETUP, S_DIV, S_MUL, S_FINISH
  } state_t;

  state_t state_r;

  // breakpoint table
  logic [DATA_W-1:0] pos_mem [MAX_SAMPLES];
  logic [DATA_W-1:0] en_mem  [MAX_SAMPLES];
  logic [DATA_W-1:0] rd_pos_r, rd_en_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  logic [CNT_W-1:0]  num_samples_r;
  logic [NW-1:0]     n_eff;
  logic [AW-1:0]     last_r;

  // query context
  logic signed [DATA_W-1:0] r_r, prev_r, p0_r, plast_r;
  logic [AW-1:0]     scan_addr_r, rdi_r, fidx_r, seg_r, a_r, b_r, eidx_r;
  logic              iss_done_r, rdv_r, found_r, seg_found_r;
  logic              bad_r, sat_r, nosl_r, interp_r, div_slope_r;
  logic [1:0]        fetch_r;
  logic signed [DATA_W-1:0] pa_r, pb_r, ea_r, eb_r, esel_r;
  logic signed [DATA_W-1:0] energy_r, slope_r;
  logic              q_neg_r, de_neg_r;
  logic [32:0]       m_r;
  logic [31:0]       dx_r;
  logic [32:0]       dr_u_r;

  // shared serial unit state
  logic [64:0]       quo_r;
  logic [32:0]       rem_r;
  logic [64:0]       acc_r;
  logic [6:0]        cnt_r;

  // shared adder
  logic [65:0]       alu_a, alu_b, alu_sum;
  logic              alu_cin;
  logic [33:0]       rem_sh;
  logic              div_ge;

  // setup arithmetic
  logic [32:0]       de_c, dr_c, de_abs, dr_abs;
  logic [32:0]       dx_c;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = start && !busy && (in_req_type == REQ_LOAD) &&
                     (32'(in_entry_index) < MAX_SAMPLES);

  // count clamped to the legal range
  always_comb begin
    if (num_samples_r < MIN_SAMPLES) begin
      n_eff = NW'(2);
    end else if (32'(num_samples_r) > MAX_SAMPLES) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = NW'(num_samples_r);
    end
  end

  // table read address: scan walks entries, fetch pulls a, b and the energy entry
  always_comb begin
    rd_addr = scan_addr_r;
    if (state_r == S_FETCH) begin
      case (fetch_r)
        2'd0:    rd_addr = a_r;
        2'd1:    rd_addr = b_r;
        default: rd_addr = eidx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[AW'(in_entry_index)] <= in_r_value;
      en_mem[AW'(in_entry_index)]  <= in_e_value;
    end
    rd_pos_r <= pos_mem[rd_addr];
    rd_en_r  <= en_mem[rd_addr];
  end

  // one adder serves the restoring divider and the shift-add multiplier
  assign rem_sh = {rem_r, quo_r[64]};
  always_comb begin
    if (state_r == S_MUL) begin
      alu_a   = {acc_r, 1'b0};
      alu_b   = dx_r[31] ? {33'b0, m_r} : '0;
      alu_cin = 1'b0;
    end else begin
      alu_a   = {32'b0, rem_sh};
      alu_b   = ~{33'b0, dr_u_r};
      alu_cin = 1'b1;
    end
  end
  assign alu_sum = alu_a + alu_b + {65'b0, alu_cin};
  assign div_ge  = !alu_sum[65];

  // segment differences
  always_comb begin
    de_c   = {eb_r[31], eb_r} - {ea_r[31], ea_r};
    dr_c   = {pb_r[31], pb_r} - {pa_r[31], pa_r};
    dx_c   = {r_r[31], r_r} - {pa_r[31], pa_r};
    de_abs = de_c[32] ? (~de_c + 33'd1) : de_c;
    dr_abs = dr_c[32] ? (~dr_c + 33'd1) : dr_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid     <= 1'b0;
      num_samples_r <= MIN_SAMPLES;
      rdv_r         <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        num_samples_r <= cfg_num_samples;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            r_r         <= in_r_value;
            energy_r    <= '0;
            slope_r     <= '0;
            bad_r       <= 1'b0;
            sat_r       <= 1'b0;
            found_r     <= 1'b0;
            seg_found_r <= 1'b0;
            scan_addr_r <= '0;
            iss_done_r  <= 1'b0;
            rdv_r       <= 1'b0;
            last_r      <= AW'(n_eff - NW'(1));
            state_r     <= (in_req_type == REQ_LOAD) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          // issue reads in order, check each one as it returns
          if (!iss_done_r) begin
            rdv_r <= 1'b1;
            rdi_r <= scan_addr_r;
            if (scan_addr_r == last_r) begin
              iss_done_r <= 1'b1;
            end else begin
              scan_addr_r <= scan_addr_r + AW'(1);
            end
          end else begin
            rdv_r <= 1'b0;
          end
          if (rdv_r) begin
            prev_r <= rd_pos_r;
            if (rdi_r == '0) begin
              p0_r <= rd_pos_r;
            end else begin
              if (!($signed(rd_pos_r) > prev_r)) bad_r <= 1'b1;
              if (!seg_found_r && (r_r > prev_r) && (r_r < $signed(rd_pos_r))) begin
                seg_found_r <= 1'b1;
                seg_r       <= rdi_r - AW'(1);
              end
            end
            if (!found_r && (r_r == $signed(rd_pos_r))) begin
              found_r <= 1'b1;
              fidx_r  <= rdi_r;
            end
            if (rdi_r == last_r) begin
              plast_r <= rd_pos_r;
              rdv_r   <= 1'b0;
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          nosl_r   <= 1'b0;
          interp_r <= 1'b0;
          fetch_r  <= 2'd0;
          state_r  <= S_FETCH;
          if (found_r) begin
            eidx_r <= fidx_r;
            if (fidx_r == '0) begin
              a_r <= '0;
              b_r <= AW'(1);
            end else if (fidx_r == last_r) begin
              a_r <= last_r - AW'(1);
              b_r <= last_r;
            end else begin
              a_r <= fidx_r - AW'(1);
              b_r <= fidx_r + AW'(1);
            end
          end else if (r_r <= p0_r) begin
            eidx_r <= '0;
            a_r    <= '0;
            b_r    <= AW'(1);
          end else if (r_r >= plast_r) begin
            eidx_r <= last_r;
            a_r    <= last_r - AW'(1);
            b_r    <= last_r;
          end else if (seg_found_r) begin
            interp_r <= 1'b1;
            eidx_r   <= seg_r;
            a_r      <= seg_r;
            b_r      <= seg_r + AW'(1);
          end else begin
            // within the ends but in no segment: last energy, flat slope
            nosl_r <= 1'b1;
            eidx_r <= last_r;
            a_r    <= last_r;
            b_r    <= last_r;
          end
        end
        S_FETCH: begin
          fetch_r <= fetch_r + 2'd1;
          case (fetch_r)
            2'd1: begin
              pa_r <= rd_pos_r;
              ea_r <= rd_en_r;
            end
            2'd2: begin
              pb_r <= rd_pos_r;
              eb_r <= rd_en_r;
            end
            2'd3: begin
              esel_r  <= rd_en_r;
              state_r <= S_SETUP;
            end
            default: ;
          endcase
        end
        S_SETUP: begin
          energy_r <= esel_r;
          de_neg_r <= de_c[32];
          q_neg_r  <= de_c[32] ^ dr_c[32];
          m_r      <= de_abs;
          dr_u_r   <= dr_abs;
          dx_r     <= dx_c[31:0];
          rem_r    <= '0;
          quo_r    <= {16'b0, de_abs, 16'b0};
          cnt_r    <= '0;
          acc_r    <= '0;
          div_slope_r <= 1'b1;
          if (nosl_r || (dr_c == '0)) begin
            slope_r <= '0;
            state_r <= interp_r ? S_MUL : S_FINISH;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= div_ge ? alu_sum[32:0] : rem_sh[32:0];
          quo_r <= {quo_r[63:0], div_ge};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) begin
            cnt_r <= '0;
            if (div_slope_r) begin
              state_r <= interp_r ? S_MUL : S_FINISH;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_MUL: begin
          acc_r <= alu_sum[64:0];
          dx_r  <= {dx_r[30:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(MUL_STEPS - 1)) begin
            cnt_r       <= '0;
            div_slope_r <= 1'b0;
            rem_r       <= '0;
            quo_r       <= alu_sum[64:0];
            state_r     <= S_DIV;
          end
        end
        S_FINISH: begin
          out_valid  <= 1'b1;
          out_energy <= energy_r;
          out_slope  <= slope_r;
          out_status <= bad_r ? STAT_BAD : (sat_r ? STAT_SAT : STAT_OK);
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // wrap up the quotient of the division that just ended
      if (state_r == S_DIV && cnt_r == 7'(DIV_STEPS - 1)) begin
        if (div_slope_r) begin
          if (q_neg_r) begin
            if ({quo_r[63:0], div_ge} > 65'h080000000) begin
              sat_r   <= 1'b1;
              slope_r <= 32'sh80000000;
            end else begin
              slope_r <= $signed(~{quo_r[30:0], div_ge} + 32'd1);
            end
          end else begin
            if ({quo_r[63:0], div_ge} > 65'h07FFFFFFF) begin
              sat_r   <= 1'b1;
              slope_r <= 32'sh7FFFFFFF;
            end else begin
              slope_r <= $signed({quo_r[30:0], div_ge});
            end
          end
        end else begin
          energy_r <= de_neg_r ? (ea_r - $signed({quo_r[30:0], div_ge}))
                               : (ea_r + $signed({quo_r[30:0], div_ge}));
        end
      end
    end
  end

endmodule

>>> src/pwli_checker.sv
// port-level checks for the piecewise linear interpolation slope unit
// depends on pwli_pkg; bound to piecewise_linear_interp_slope_unit
module pwli_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_req_type,
  input logic                          out_valid,
  input logic [pwli_pkg::DATA_W-1:0]   out_energy,
  input logic [pwli_pkg::DATA_W-1:0]   out_slope,
  input logic [pwli_pkg::STAT_W-1:0]   out_status
);
  import pwli_pkg::*;

  // an accepted item holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  // a load item passes straight to the finish state and answers with all-zero fields
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_LOAD) |-> ##2
      (out_valid && out_energy == '0 && out_slope == '0 && out_status == STAT_OK))
    else $error("load item result wrong");

  // the result strobe comes only when the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // no result without an item in flight the cycle before
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("spurious result");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_BAD ||
                   out_status == STAT_SAT)) else $error("bad status code");

endmodule

bind piecewise_linear_interp_slope_unit pwli_checker u_pwli_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_energy  (out_energy),
  .out_slope   (out_slope),
  .out_status  (out_status)
);
